FILE: rtl/tcw_pkg.sv
// Shared types, constants and helpers for the text console writer.
// No dependencies; imported by text_console_writer_top and the testbench.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int AW      = $clog2(CELLS);
    localparam int LW      = 12;

    localparam logic [15:0] CELL_RESET = 16'h0720;
    localparam logic [7:0]  CH_NL      = 8'h0A;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  TAB_MASK   = ~8'd3;

    localparam logic [1:0] REG_FG = 2'd0;
    localparam logic [1:0] REG_BG = 2'd1;

    typedef enum logic [2:0] {
        F_PUT_CUR = 3'd0,
        F_PUT_POS = 3'd1,
        F_FILL    = 3'd2,
        F_BOX     = 3'd3,
        F_CLS     = 3'd4,
        F_CLL     = 3'd5,
        F_SETCUR  = 3'd6,
        F_READ    = 3'd7
    } t_func;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] ch;
        logic [6:0] col_x;
        logic [4:0] row_y;
        logic [6:0] rect_width;
        logic [4:0] rect_height;
    } t_in;

    typedef struct packed {
        logic [15:0] read_data;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_linear;
    } t_out;

    // Linear cell position row*COLUMNS+col.
    function automatic logic [LW-1:0] lin(input logic [4:0] row, input logic [6:0] col);
        logic [LW-1:0] p;
        p = LW'(row) * LW'(COLUMNS) + LW'(col);
        return p;
    endfunction

endpackage

FILE: rtl/text_console_writer_top.sv
// Text console writer top level: command sequencer around the cell RAM.
// Depends on tcw_pkg and tcw_ram.
//
// A command beat is taken only while the block is idle; each command returns
// exactly one result beat. Fills and boxes walk every cell of the rectangle,
// clear line walks one row and clear screen walks every cell. A put that
// scrolls copies (ROWS-1)*COLUMNS cells at one cell a cycle through the RAM's
// read port and write port, then blanks the last row. After reset the RAM's
// ROWS*COLUMNS cells (2000 by default) are cleared to 0x0720 with input
// stalled; configuration writes are taken throughout.
module text_console_writer_top
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data
);
    typedef enum logic [7:0] {
        S_CLR    = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_RWAIT  = 8'b0000_1000,
        S_SCROLL = 8'b0001_0000,
        S_SDRAIN = 8'b0010_0000,
        S_WALK   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state      r_state;
    t_in         r_in;
    logic [3:0]  r_fg, r_bg;
    logic [6:0]  r_ccol;
    logic [4:0]  r_crow;
    logic [15:0] r_rd;
    // walker
    logic [6:0]  r_x0, r_xe, r_wc;
    logic [4:0]  r_y0, r_ye, r_wr;
    logic        r_box, r_wret_idle;
    logic [15:0] r_wdata;
    // scroll copy
    logic [AW-1:0] r_sa, r_pa;
    logic          r_sv;
    logic          r_ovalid;
    t_out          r_out;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata, rdata;
    logic [15:0]   blank, put_cell;
    logic          pos_ok, rect_ok, walk_hit, walk_last;
    logic [7:0]    tab_col;
    logic [7:0]    inc_col;
    logic [LW-1:0] cur_lin;
    logic [LW-1:0] walk_lin;
    logic [LW-1:0] pos_lin;

    tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Decode the latched command
    always_comb begin
        blank     = {r_bg, r_fg, CH_SPACE};
        put_cell  = {r_bg, r_fg, r_in.ch};
        pos_ok    = (32'(r_in.col_x) < COLUMNS) && (32'(r_in.row_y) < ROWS);
        rect_ok   = (32'(r_in.col_x) + 32'(r_in.rect_width) <= COLUMNS)
                 && (32'(r_in.row_y) + 32'(r_in.rect_height) <= ROWS);
        walk_hit  = !r_box || r_wc == r_x0 || r_wc == r_xe || r_wr == r_y0 || r_wr == r_ye;
        walk_last = (r_wc == r_xe) && (r_wr == r_ye);
        tab_col   = (8'(r_ccol) + 8'd4) & TAB_MASK;
        inc_col   = 8'(r_ccol) + 8'd1;
        cur_lin   = lin(r_crow, r_ccol);
        walk_lin  = lin(r_wr, r_wc);
        pos_lin   = lin(r_in.row_y, r_in.col_x);
    end

    // RAM port steering
    always_comb begin
        we    = 1'b0;
        waddr = walk_lin[AW-1:0];
        wdata = r_wdata;
        raddr = r_sa;
        unique case (r_state)
            S_CLR, S_WALK: begin
                we = walk_hit;
            end
            S_EXEC: begin
                raddr = pos_lin[AW-1:0];
                wdata = put_cell;
                if (t_func'(r_in.func) == F_PUT_CUR) begin
                    waddr = cur_lin[AW-1:0];
                    we    = r_in.ch != CH_NL && r_in.ch != CH_CR && r_in.ch != CH_TAB;
                end else if (t_func'(r_in.func) == F_PUT_POS) begin
                    waddr = pos_lin[AW-1:0];
                    we    = pos_ok;
                end
            end
            S_SCROLL, S_SDRAIN: begin
                we    = r_sv;
                waddr = r_pa - AW'(COLUMNS);
                wdata = rdata;
            end
            S_IDLE, S_RWAIT, S_DONE: begin
                we = 1'b0;
            end
            default: we = 1'b0;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_fg        <= 4'd7;
            r_bg        <= 4'd0;
            r_ccol      <= '0;
            r_crow      <= '0;
            r_ovalid    <= 1'b0;
            r_sv        <= 1'b0;
            r_x0        <= '0;
            r_xe        <= 7'(COLUMNS - 1);
            r_y0        <= '0;
            r_ye        <= 5'(ROWS - 1);
            r_wc        <= '0;
            r_wr        <= '0;
            r_box       <= 1'b0;
            r_wret_idle <= 1'b1;
            r_wdata     <= CELL_RESET;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FG:  r_fg <= i_cfg_data;
                    REG_BG:  r_bg <= i_cfg_data;
                    default: ;
                endcase
            end
            // drop the result once taken, unless a new one loads this cycle
            if (r_ovalid && !i_out_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_rd    <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (t_func'(r_in.func))
                        F_PUT_CUR: begin
                            if (r_in.ch == CH_CR) begin
                                r_ccol  <= '0;
                                r_state <= S_DONE;
                            end else if (r_in.ch == CH_NL
                                      || (r_in.ch == CH_TAB && 32'(tab_col) >= COLUMNS)
                                      || (r_in.ch != CH_TAB && 32'(inc_col) >= COLUMNS)) begin
                                r_ccol <= '0;
                                if (32'(r_crow) + 1 >= ROWS) begin
                                    r_sa    <= AW'(COLUMNS);
                                    r_sv    <= 1'b0;
                                    r_state <= S_SCROLL;
                                end else begin
                                    r_crow  <= r_crow + 5'd1;
                                    r_state <= S_DONE;
                                end
                            end else if (r_in.ch == CH_TAB) begin
                                r_ccol  <= tab_col[6:0];
                                r_state <= S_DONE;
                            end else begin
                                r_ccol  <= inc_col[6:0];
                                r_state <= S_DONE;
                            end
                        end
                        F_PUT_POS: begin
                            r_state <= S_DONE;
                        end
                        F_FILL, F_BOX: begin
                            if (rect_ok && r_in.rect_width != '0 && r_in.rect_height != '0) begin
                                r_box   <= t_func'(r_in.func) == F_BOX;
                                r_wdata <= put_cell;
                                r_x0    <= r_in.col_x;
                                r_xe    <= r_in.col_x + r_in.rect_width - 7'd1;
                                r_y0    <= r_in.row_y;
                                r_ye    <= r_in.row_y + r_in.rect_height - 5'd1;
                                r_wc    <= r_in.col_x;
                                r_wr    <= r_in.row_y;
                                r_state <= S_WALK;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        F_CLS: begin
                            r_ccol  <= '0;
                            r_crow  <= '0;
                            r_box   <= 1'b0;
                            r_wdata <= blank;
                            r_x0    <= '0;
                            r_xe    <= 7'(COLUMNS - 1);
                            r_wc    <= '0;
                            r_y0    <= '0;
                            r_ye    <= 5'(ROWS - 1);
                            r_wr    <= '0;
                            r_state <= S_WALK;
                        end
                        F_CLL: begin
                            if (32'(r_in.row_y) < ROWS) begin
                                r_box   <= 1'b0;
                                r_wdata <= blank;
                                r_x0    <= '0;
                                r_xe    <= 7'(COLUMNS - 1);
                                r_wc    <= '0;
                                r_y0    <= r_in.row_y;
                                r_ye    <= r_in.row_y;
                                r_wr    <= r_in.row_y;
                                r_state <= S_WALK;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        F_SETCUR: begin
                            if (pos_ok) begin
                                r_ccol <= r_in.col_x;
                                r_crow <= r_in.row_y;
                            end
                            r_state <= S_DONE;
                        end
                        F_READ: begin
                            r_state <= pos_ok ? S_RWAIT : S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_RWAIT: begin
                    r_rd    <= rdata;
                    r_state <= S_DONE;
                end
                S_SCROLL: begin
                    // read one row ahead, write the previous read back
                    r_pa <= r_sa;
                    r_sv <= 1'b1;
                    r_sa <= r_sa + AW'(1);
                    if (32'(r_sa) == CELLS - 1) begin
                        r_state <= S_SDRAIN;
                    end
                end
                S_SDRAIN: begin
                    // write the last copied cell, then blank the bottom row
                    r_sv    <= 1'b0;
                    r_box   <= 1'b0;
                    r_wdata <= blank;
                    r_x0    <= '0;
                    r_xe    <= 7'(COLUMNS - 1);
                    r_wc    <= '0;
                    r_y0    <= 5'(ROWS - 1);
                    r_ye    <= 5'(ROWS - 1);
                    r_wr    <= 5'(ROWS - 1);
                    r_state <= S_WALK;
                end
                S_CLR, S_WALK: begin
                    if (walk_last) begin
                        r_state     <= r_wret_idle ? S_IDLE : S_DONE;
                        r_wret_idle <= 1'b0;
                    end else if (r_wc == r_xe) begin
                        r_wc <= r_x0;
                        r_wr <= r_wr + 5'd1;
                    end else begin
                        r_wc <= r_wc + 7'd1;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid                <= 1'b1;
                        r_out.read_data         <= r_rd;
                        r_out.cursor_col        <= r_ccol;
                        r_out.cursor_row        <= r_crow;
                        r_out.cursor_linear     <= cur_lin[10:0];
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Checks
    a_clr_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> o_in_stall)
        else $error("input taken during clear pass");
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_data.cursor_col) < COLUMNS
                      && 32'(o_out_data.cursor_row) < ROWS))
        else $error("cursor out of range");
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> 32'(waddr) < CELLS)
        else $error("cell write out of range");
endmodule

FILE: rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: dv/tb.sv
// Self-checking testbench for text_console_writer_top: a queue-fed driver, an
// in-line screen and cursor predictor, and a result monitor. Depends on tcw_pkg.
// Covers directed corner commands, then random traffic under changing back-pressure.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam int         HANG_LIMIT  = 60000;
    localparam int         DRAIN_WAIT  = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in        i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out       o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [3:0] i_cfg_data = '0;

    text_console_writer_top u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state: screen contents, cursor and colors
    logic [15:0] screen [CELLS];
    int          cur_c, cur_r;
    logic [3:0]  fg_col, bg_col;

    t_in  cmd_q [$];
    t_out result_q [$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic in_took = 1'b0;
    int   quiet_cycles = 0;

    function automatic logic [15:0] paint(input logic [7:0] c);
        return {bg_col, fg_col, c};
    endfunction

    function automatic void poke(input int x, input int y, input logic [7:0] c);
        if (x < COLUMNS && y < ROWS) screen[y*COLUMNS + x] = paint(c);
    endfunction

    function automatic void blank_row(input int y);
        for (int x = 0; x < COLUMNS; x++) screen[y*COLUMNS + x] = paint(CH_SPACE);
    endfunction

    function automatic void line_feed();
        cur_c = 0;
        cur_r++;
        if (cur_r >= ROWS) begin
            for (int k = 0; k < (ROWS-1)*COLUMNS; k++) screen[k] = screen[k + COLUMNS];
            blank_row(ROWS-1);
            cur_r = ROWS-1;
        end
    endfunction

    // Apply one command to the predicted screen and return the expected beat
    function automatic t_out console_step(input t_in cmd);
        t_out        r;
        logic [15:0] rd;
        int          x, y, w, h;
        rd = '0;
        x = cmd.col_x; y = cmd.row_y; w = cmd.rect_width; h = cmd.rect_height;
        case (t_func'(cmd.func))
            F_PUT_CUR: begin
                if (cmd.ch == CH_NL) begin
                    line_feed();
                end else if (cmd.ch == CH_CR) begin
                    cur_c = 0;
                end else if (cmd.ch == CH_TAB) begin
                    cur_c = (cur_c + 4) & ~3;
                    if (cur_c >= COLUMNS) line_feed();
                end else begin
                    poke(cur_c, cur_r, cmd.ch);
                    cur_c++;
                    if (cur_c >= COLUMNS) line_feed();
                end
            end
            F_PUT_POS: poke(x, y, cmd.ch);
            F_FILL: begin
                if (x + w <= COLUMNS && y + h <= ROWS)
                    for (int j = 0; j < h; j++)
                        for (int i = 0; i < w; i++) poke(x + i, y + j, cmd.ch);
            end
            F_BOX: begin
                if (w != 0 && h != 0 && x + w <= COLUMNS && y + h <= ROWS) begin
                    for (int i = 0; i < w; i++) begin
                        poke(x + i, y, cmd.ch);
                        poke(x + i, y + h - 1, cmd.ch);
                    end
                    for (int j = 1; j + 1 < h; j++) begin
                        poke(x, y + j, cmd.ch);
                        poke(x + w - 1, y + j, cmd.ch);
                    end
                end
            end
            F_CLS: begin
                for (int k = 0; k < CELLS; k++) screen[k] = paint(CH_SPACE);
                cur_c = 0;
                cur_r = 0;
            end
            F_CLL: if (y < ROWS) blank_row(y);
            F_SETCUR: begin
                if (x < COLUMNS && y < ROWS) begin
                    cur_c = x;
                    cur_r = y;
                end
            end
            default: if (x < COLUMNS && y < ROWS) rd = screen[y*COLUMNS + x];
        endcase
        r.read_data     = rd;
        r.cursor_col    = 7'(cur_c);
        r.cursor_row    = 5'(cur_r);
        r.cursor_linear = 11'(cur_r*COLUMNS + cur_c);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // Predict on every accepted command beat
    always @(posedge i_clk) begin
        in_took <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) result_q.push_back(console_step(i_in_data));
    end

    // Check every accepted result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = result_q.pop_front();
                if (o_out_data.read_data != want.read_data)
                    report_mismatch("read_data", o_out_data.read_data, want.read_data);
                if (o_out_data.cursor_col != want.cursor_col)
                    report_mismatch("cursor_col", o_out_data.cursor_col, want.cursor_col);
                if (o_out_data.cursor_row != want.cursor_row)
                    report_mismatch("cursor_row", o_out_data.cursor_row, want.cursor_row);
                if (o_out_data.cursor_linear != want.cursor_linear)
                    report_mismatch("cursor_linear", o_out_data.cursor_linear,
                                    want.cursor_linear);
            end
        end
    end

    // Driver: advance to the next command once the current beat is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= cmd_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [3:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == REG_FG) fg_col = val;
        else if (idx == REG_BG) bg_col = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_cmd(input t_func f, input logic [7:0] c, input int x, input int y,
                             input int w, input int h);
        t_in cmd;
        cmd.func = f; cmd.ch = c; cmd.col_x = 7'(x); cmd.row_y = 5'(y);
        cmd.rect_width = 7'(w); cmd.rect_height = 5'(h);
        cmd_q.push_back(cmd);
    endtask

    task automatic wait_idle();
        while (cmd_q.size() != 0 || i_in_valid || result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Random command mix: mostly in-range, small rectangles, rare full-screen work
    function automatic t_in random_cmd();
        t_in cmd;
        int  p;
        cmd = t_in'(35'({$urandom, $urandom}));
        p = $urandom_range(99);
        if (p < 35)      cmd.func = F_PUT_CUR;
        else if (p < 47) cmd.func = F_PUT_POS;
        else if (p < 57) cmd.func = F_FILL;
        else if (p < 67) cmd.func = F_BOX;
        else if (p < 69) cmd.func = F_CLS;
        else if (p < 74) cmd.func = F_CLL;
        else if (p < 84) cmd.func = F_SETCUR;
        else             cmd.func = F_READ;
        case ($urandom_range(9))
            0: cmd.ch = CH_NL;
            1: cmd.ch = CH_TAB;
            2: cmd.ch = CH_CR;
            default: ;
        endcase
        if ($urandom_range(9) != 0) begin
            cmd.col_x = 7'($urandom_range(COLUMNS-1));
            cmd.row_y = 5'($urandom_range(ROWS-1));
        end
        if ($urandom_range(19) != 0) begin
            cmd.rect_width  = 7'($urandom_range(8));
            cmd.rect_height = 5'($urandom_range(5));
        end
        return cmd;
    endfunction

    initial begin
        for (int k = 0; k < CELLS; k++) screen[k] = CELL_RESET;
        cur_c = 0; cur_r = 0; fg_col = 4'd7; bg_col = 4'd0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners
        cfg_write(REG_FG, 4'hF);
        cfg_write(REG_BG, 4'hF);
        queue_cmd(F_READ, 8'h00, 0, 0, 0, 0);
        queue_cmd(F_PUT_CUR, 8'hFF, 0, 0, 0, 0);
        queue_cmd(F_PUT_CUR, 8'h00, 0, 0, 0, 0);
        queue_cmd(F_READ, 8'h00, 0, 0, 0, 0);
        queue_cmd(F_PUT_POS, 8'h80, COLUMNS-1, ROWS-1, 0, 0);
        queue_cmd(F_READ, 8'h00, COLUMNS-1, ROWS-1, 0, 0);
        queue_cmd(F_PUT_POS, 8'h41, COLUMNS, 0, 0, 0);
        queue_cmd(F_READ, 8'h00, 127, 31, 0, 0);
        queue_cmd(F_SETCUR, 8'h00, 127, 31, 0, 0);
        queue_cmd(F_SETCUR, 8'h00, 77, 3, 0, 0);
        queue_cmd(F_PUT_CUR, CH_TAB, 0, 0, 0, 0);
        queue_cmd(F_PUT_CUR, CH_TAB, 0, 0, 0, 0);
        queue_cmd(F_PUT_CUR, CH_CR, 0, 0, 0, 0);
        queue_cmd(F_SETCUR, 8'h00, 0, ROWS-1, 0, 0);
        queue_cmd(F_PUT_CUR, CH_NL, 0, 0, 0, 0);
        queue_cmd(F_SETCUR, 8'h00, COLUMNS-1, ROWS-1, 0, 0);
        queue_cmd(F_PUT_CUR, 8'h5A, 0, 0, 0, 0);
        queue_cmd(F_READ, 8'h00, COLUMNS-2, ROWS-2, 0, 0);
        queue_cmd(F_BOX, 8'h2A, 3, 3, 0, 4);
        queue_cmd(F_BOX, 8'h2A, 3, 3, 6, 4);
        queue_cmd(F_FILL, 8'h23, 1, 1, 127, 31);
        queue_cmd(F_FILL, 8'hB1, 0, 0, COLUMNS, ROWS);
        queue_cmd(F_CLL, 8'h00, 0, 31, 0, 0);
        queue_cmd(F_CLL, 8'h00, 0, ROWS-1, 0, 0);
        queue_cmd(F_CLS, 8'h00, 0, 0, 0, 0);
        wait_idle();

        // Random phases under different back-pressure and colors
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 9;  recv_idle_pct = 73;
                    cfg_write(REG_FG, 4'h0); cfg_write(REG_BG, 4'h0);
                    cfg_write(REG_SPARE_A, 4'hA);
                end
                1: begin
                    send_idle_pct = 73; recv_idle_pct = 9;
                    cfg_write(REG_FG, 4'($urandom)); cfg_write(REG_BG, 4'($urandom));
                    cfg_write(REG_SPARE_B, 4'h5);
                end
                default: begin
                    send_idle_pct = 0;  recv_idle_pct = 0;
                    cfg_write(REG_FG, 4'h7); cfg_write(REG_BG, 4'hF);
                end
            endcase
            for (int n = 0; n < 267; n++) cmd_q.push_back(random_cmd());
            wait_idle();
        end

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
